FILE: design/brms_pkg.sv
// ----------------------------------------------------------------------------
// Block RMS meter package
// Shared widths, register indexes, controller states and command types.
// ----------------------------------------------------------------------------
package brms_pkg;

    // Default values for the top-level parameters.
    localparam int BLOCK_MAX_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths.
    localparam int SAMPLE_W   = 12;
    localparam int LEN_W      = 7;
    localparam int CFG_DATA_W = 12;
    localparam int RMS_W      = 16;
    localparam int MEAN_W     = 24;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int SUM_W      = 30;

    // The dividend is the sum scaled by 256; the quotient is reused as the radicand.
    localparam int FRAC_SHIFT = 8;
    localparam int DIVD_W     = SUM_W + FRAC_SHIFT;
    localparam int ROOT_W     = DIVD_W / 2;
    localparam int SQREM_W    = ROOT_W + 1;

    localparam int DIV_STEPS  = DIVD_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Configuration register indexes.
    localparam logic CFG_OFFSET_CODE = 1'b0;
    localparam logic CFG_BLOCK_LEN   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 12'd2048;
    localparam logic [LEN_W-1:0]    LEN_RESET    = 7'd50;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV,
        ST_ROOT_INIT,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_sample;
        logic square;
        logic accum;
        logic div_step;
        logic root_init;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic blk_done;
        logic res_free;
    } t_status;

endpackage

FILE: design/brms_ctrl.sv
// ----------------------------------------------------------------------------
// Block RMS meter controller
// Sequences sample intake, block division, square root and result hand-off.
// ----------------------------------------------------------------------------
module brms_ctrl
    import brms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_sample_valid,
    output logic    o_sample_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and step counter.
    always_comb begin
        n_state = r_state;
        n_step  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_sample_valid) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                n_state = i_status.blk_done ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_ROOT_INIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_ROOT_INIT: begin
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_OUT: begin
                if (i_status.res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd          = '0;
        o_sample_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_sample_ready    = 1'b1;
                o_cmd.load_sample = i_sample_valid;
            end
            ST_SQUARE:    o_cmd.square    = 1'b1;
            ST_ACCUM:     o_cmd.accum     = 1'b1;
            ST_DIV:       o_cmd.div_step  = 1'b1;
            ST_ROOT_INIT: o_cmd.root_init = 1'b1;
            ST_SQRT:      o_cmd.sqrt_step = 1'b1;
            ST_OUT:       o_cmd.out_load  = i_status.res_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // In the square root iteration the step counter never runs past its length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> (r_step < STEP_W'(SQRT_STEPS)))
        else $error("square root step counter out of range");

    // A completed block always goes straight into division.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCUM && i_status.blk_done) |=> (r_state == ST_DIV && r_step == '0))
        else $error("completed block did not start division");

endmodule

FILE: design/brms_dpath.sv
// ----------------------------------------------------------------------------
// Block RMS meter datapath
// Offset removal, squaring, accumulation, shift-subtract divider and square root.
// ----------------------------------------------------------------------------
module brms_dpath
    import brms_pkg::*;
#(
    parameter int BLOCK_MAX   = BLOCK_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [RMS_W-1:0]      o_rms_q4,
    output logic [MEAN_W-1:0]     o_mean_square
);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= SAMPLE_W) ? '1 :
        SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    logic [SAMPLE_W-1:0] r_offset_code;
    logic [LEN_W-1:0]    r_block_len;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SQ_W-1:0]     r_square;
    logic [SUM_W-1:0]    r_sum;
    logic [LEN_W-1:0]    r_count;
    logic [LEN_W-1:0]    r_div_len;
    logic [LEN_W-1:0]    r_div_rem;
    logic [DIVD_W-1:0]   r_quo;
    logic [SQREM_W-1:0]  r_sq_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [MEAN_W-1:0]   r_mean;
    logic                r_res_valid;
    logic [RMS_W-1:0]    r_res_rms;
    logic [MEAN_W-1:0]   r_res_mean;

    logic [SAMPLE_W-1:0] s_masked;
    logic [SAMPLE_W-1:0] o_masked;
    logic [SAMPLE_W-1:0] dev;
    logic [LEN_W-1:0]    eff_len;
    logic [LEN_W:0]      count_inc;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_sat;
    logic [LEN_W:0]      div_shift;
    logic [LEN_W+1:0]    div_diff;
    logic [SQREM_W+1:0]  sq_shift;
    logic [SQREM_W+1:0]  sq_trial;
    logic [SQREM_W+2:0]  sq_diff;
    logic [DIVD_W-FRAC_SHIFT-1:0] quo_mean;

    // Offset removal and effective block length.
    always_comb begin
        s_masked = r_sample & SAMPLE_MASK;
        o_masked = r_offset_code & SAMPLE_MASK;
        dev      = (s_masked >= o_masked) ? (s_masked - o_masked) : (o_masked - s_masked);
        if (r_block_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(r_block_len) > BLOCK_MAX) begin
            eff_len = LEN_W'(BLOCK_MAX);
        end else begin
            eff_len = r_block_len;
        end
        count_inc = {1'b0, r_count} + 1'b1;
        sum_add   = {1'b0, r_sum} + (SUM_W + 1)'(r_square);
        sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end

    // One quotient bit and one root bit per step.
    always_comb begin
        div_shift = {r_div_rem, r_quo[DIVD_W-1]};
        div_diff  = {1'b0, div_shift} - (LEN_W + 2)'(r_div_len);
        sq_shift  = {r_sq_rem, r_quo[DIVD_W-1 -: 2]};
        sq_trial  = (SQREM_W + 2)'({r_root, 2'b01});
        sq_diff   = {1'b0, sq_shift} - {1'b0, sq_trial};
        quo_mean  = r_quo[DIVD_W-1:FRAC_SHIFT];
    end

    assign o_status.blk_done = (count_inc >= {1'b0, eff_len});
    assign o_status.res_free = !r_res_valid || i_res_ready;

    // Configuration registers and block accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_code <= OFFSET_RESET;
            r_block_len   <= LEN_RESET;
            r_sum         <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OFFSET_CODE: r_offset_code <= i_cfg_data;
                    CFG_BLOCK_LEN:   r_block_len   <= i_cfg_data[LEN_W-1:0];
                    default:         r_block_len   <= r_block_len;
                endcase
            end
            if (i_cmd.accum) begin
                if (o_status.blk_done) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= sum_sat;
                    r_count <= count_inc[LEN_W-1:0];
                end
            end
        end
    end

    // Arithmetic working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_sample;
        end
        if (i_cmd.square) begin
            r_square <= dev * dev;
        end
        if (i_cmd.accum && o_status.blk_done) begin
            r_quo     <= {sum_sat, FRAC_SHIFT'(0)};
            r_div_rem <= '0;
            r_div_len <= eff_len;
        end
        if (i_cmd.div_step) begin
            if (!div_diff[LEN_W+1]) begin
                r_div_rem <= div_diff[LEN_W-1:0];
                r_quo     <= {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                r_div_rem <= div_shift[LEN_W-1:0];
                r_quo     <= {r_quo[DIVD_W-2:0], 1'b0};
            end
        end
        if (i_cmd.root_init) begin
            r_mean   <= (quo_mean > (DIVD_W - FRAC_SHIFT)'({MEAN_W{1'b1}})) ? '1 :
                        quo_mean[MEAN_W-1:0];
            r_sq_rem <= '0;
            r_root   <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_quo <= {r_quo[DIVD_W-3:0], 2'b00};
            if (!sq_diff[SQREM_W+2]) begin
                r_sq_rem <= sq_diff[SQREM_W-1:0];
                r_root   <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_sq_rem <= sq_shift[SQREM_W-1:0];
                r_root   <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_res_rms  <= (r_root > ROOT_W'({RMS_W{1'b1}})) ? '1 : r_root[RMS_W-1:0];
            r_res_mean <= r_mean;
        end
    end

    // Result holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_rms_q4      = r_res_rms;
    assign o_mean_square = r_res_mean;

    // A new result never overwrites one that has not been transferred.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_res_valid || i_res_ready))
        else $error("result overwritten before transfer");

    // The division remainder stays below the divisor.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_div_rem < r_div_len))
        else $error("division remainder not below divisor");

    // The square root remainder never exceeds twice the partial root.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_step |-> (r_sq_rem <= {r_root, 1'b0}))
        else $error("square root remainder out of bound");

    // Loading a result makes it visible on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_res_valid)
        else $error("loaded result not presented");

endmodule

FILE: design/block_rms_meter_unit.sv
// ----------------------------------------------------------------------------
// Block RMS meter
// Removes a DC offset from converter samples and reports block RMS and mean square.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                        Payload
//  sample    in         i_sample_valid / o_sample_ready  i_sample[11:0]
//  result    out        o_result_valid / i_result_ready  o_rms_q4[15:0], o_mean_square[23:0]
//  config    in         i_cfg_we (no wait)               i_cfg_index, i_cfg_data[11:0]
//
// A sample that does not complete a block is captured, squared and accumulated.
// The sample that completes a block then goes through a shift-subtract divider that
// yields one quotient bit per cycle over the 38-bit scaled sum; then the square root
// unit yields one root bit per cycle into a 19-bit root, reusing the quotient register.
// Reset is synchronous and active low; it restores the configuration defaults and
// clears the accumulator, the sample count and the result valid flag.
// A finished result waits in its own register, so new samples are taken while it
// stalls; only a second completed block waits for the first one's transfer.
// ----------------------------------------------------------------------------
module block_rms_meter_unit
    import brms_pkg::*;
#(
    parameter int BLOCK_MAX   = BLOCK_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Sample channel.
    input  logic                  i_sample_valid,
    output logic                  o_sample_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    // Result channel.
    output logic                  o_result_valid,
    input  logic                  i_result_ready,
    output logic [RMS_W-1:0]      o_rms_q4,
    output logic [MEAN_W-1:0]     o_mean_square
);

    // Commands flow from the controller to the datapath; status flows back.
    t_cmd    cmd;
    t_status status;

    brms_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    // The datapath holds the configuration, the block accumulator, the shared
    // divider and root registers, and the result register toward the consumer.
    brms_dpath #(
        .BLOCK_MAX   (BLOCK_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_sample),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_res_valid   (o_result_valid),
        .i_res_ready   (i_result_ready),
        .o_rms_q4      (o_rms_q4),
        .o_mean_square (o_mean_square)
    );

endmodule

FILE: bench/brms_checker.sv
// ----------------------------------------------------------------------------
// Block RMS meter checker
// Follows the configuration port and both channels, predicts the block results
// from the accepted samples and compares every result transfer with them.
// ----------------------------------------------------------------------------
module brms_checker
    import brms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_sample_valid,
    input  logic                  i_sample_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_result_valid,
    input  logic                  i_result_ready,
    input  logic [RMS_W-1:0]      i_rms_q4,
    input  logic [MEAN_W-1:0]     i_mean_square,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [63:0] SUM_LIMIT  = (64'd1 << SUM_W) - 1;
    localparam logic [63:0] MEAN_LIMIT = (64'd1 << MEAN_W) - 1;
    localparam logic [63:0] RMS_LIMIT  = (64'd1 << RMS_W) - 1;

    typedef struct packed {
        logic [RMS_W-1:0]  rms_q4;
        logic [MEAN_W-1:0] mean_square;
    } t_block_stats;

    t_block_stats        block_stats_q[$];
    logic [SAMPLE_W-1:0] offset_code  = OFFSET_RESET;
    logic [LEN_W-1:0]    block_len    = LEN_RESET;
    logic [SUM_W-1:0]    square_sum   = '0;
    logic [LEN_W-1:0]    sample_count = '0;
    int                  mismatches   = 0;
    int                  blocks_due   = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = blocks_due;

    // Builds the root one bit at a time from the top, keeping a bit when its square still fits.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] value);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Adds the squared deviation of one sample and closes the block when it is full.
    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] code);
        logic [SAMPLE_W-1:0] deviation;
        logic [63:0]         total;
        logic [63:0]         eff_len;
        logic [63:0]         mean;
        logic [63:0]         root;
        t_block_stats        stats;
        deviation = (code >= offset_code) ? code - offset_code : offset_code - code;
        if (block_len == 0) begin
            eff_len = 64'd1;
        end else if (block_len > BLOCK_MAX_DEF) begin
            eff_len = 64'(BLOCK_MAX_DEF);
        end else begin
            eff_len = 64'(block_len);
        end
        total = 64'(square_sum) + 64'(deviation) * 64'(deviation);
        if (total > SUM_LIMIT) begin
            total = SUM_LIMIT;
        end
        sample_count = sample_count + 1'b1;
        if (sample_count >= eff_len) begin
            mean = total / eff_len;
            root = floor_sqrt((total << FRAC_SHIFT) / eff_len);
            if (mean > MEAN_LIMIT) begin
                mean = MEAN_LIMIT;
            end
            if (root > RMS_LIMIT) begin
                root = RMS_LIMIT;
            end
            stats.rms_q4      = root[RMS_W-1:0];
            stats.mean_square = mean[MEAN_W-1:0];
            block_stats_q.push_back(stats);
            square_sum   = '0;
            sample_count = '0;
        end else begin
            square_sum = total[SUM_W-1:0];
        end
    endtask

    task automatic compare_result();
        t_block_stats want;
        if (block_stats_q.size() == 0) begin
            $display("%0t: result transfer with no block pending: rms_q4 %0d mean_square %0d",
                     $time, i_rms_q4, i_mean_square);
            mismatches++;
        end else begin
            want = block_stats_q.pop_front();
            if (i_rms_q4 !== want.rms_q4) begin
                $display("%0t: rms_q4 expected %0d, actual %0d", $time, want.rms_q4, i_rms_q4);
                mismatches++;
            end
            if (i_mean_square !== want.mean_square) begin
                $display("%0t: mean_square expected %0d, actual %0d",
                         $time, want.mean_square, i_mean_square);
                mismatches++;
            end
        end
    endtask

    // A result can never leave in the cycle its block closes, so the result transfer
    // is checked before the sample of the same edge is accumulated.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offset_code  = OFFSET_RESET;
            block_len    = LEN_RESET;
            square_sum   = '0;
            sample_count = '0;
        end else begin
            if (i_result_valid && i_result_ready) begin
                compare_result();
            end
            if (i_sample_valid && i_sample_ready) begin
                accumulate_sample(i_sample);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OFFSET_CODE: offset_code = i_cfg_data[SAMPLE_W-1:0];
                    CFG_BLOCK_LEN:   block_len   = i_cfg_data[LEN_W-1:0];
                    default:         ;
                endcase
            end
        end
        blocks_due = block_stats_q.size();
    end

endmodule

FILE: bench/block_rms_meter_unit_tb.sv
// ----------------------------------------------------------------------------
// Block RMS meter testbench
// Drives converter samples and register writes into the meter, stalls the
// result side at random and lets the checker judge every result transfer.
// ----------------------------------------------------------------------------
module block_rms_meter_unit_tb;
    import brms_pkg::*;

    // Roughly how many samples the run sends in total.
    localparam int SAMPLE_TARGET = 400;
    // The last samples of the run go out with no gaps on either side.
    localparam int GAPLESS_TAIL  = 60;
    // A sample that does not close a block keeps the meter busy through capture, square
    // and accumulate; this margin covers it before any register write and at the end.
    localparam int SETTLE_CYCLES = 16;
    // A closing sample also runs the divider and the square root; even with every
    // sample closing a block and every gap at its longest, the run needs well under this.
    localparam int CYCLE_LIMIT   = 400000;

    // Sample shapes used by the random phases.
    localparam int SHAPE_UNIFORM  = 0;
    localparam int SHAPE_EXTREMES = 1;
    localparam int SHAPE_NEAR_DC  = 2;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic                  cfg_index      = CFG_OFFSET_CODE;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  sample_valid   = 1'b0;
    logic                  sample_ready;
    logic [SAMPLE_W-1:0]   sample         = '0;
    logic                  result_valid;
    logic                  result_ready   = 1'b0;
    logic [RMS_W-1:0]      rms_q4;
    logic [MEAN_W-1:0]     mean_square;

    int fail_count;
    int blocks_pending;
    int samples_sent = 0;
    int cycle_count  = 0;
    int ready_hold   = 0;
    bit send_gaps    = 1'b1;
    bit ready_gaps   = 1'b1;

    block_rms_meter_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_sample_valid (sample_valid),
        .o_sample_ready (sample_ready),
        .i_sample       (sample),
        .o_result_valid (result_valid),
        .i_result_ready (result_ready),
        .o_rms_q4       (rms_q4),
        .o_mean_square  (mean_square)
    );

    brms_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_sample_valid (sample_valid),
        .i_sample_ready (sample_ready),
        .i_sample       (sample),
        .i_result_valid (result_valid),
        .i_result_ready (result_ready),
        .i_rms_q4       (rms_q4),
        .i_mean_square  (mean_square),
        .o_fail_count   (fail_count),
        .o_pending      (blocks_pending)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The result side drops ready for a random burst while gaps are on.
    // Each edge makes exactly one assignment to ready.
    always @(posedge clk) begin
        if (ready_hold > 0) begin
            result_ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end else if (ready_gaps && $urandom_range(0, 5) == 0) begin
            result_ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 2);
        end else begin
            result_ready <= 1'b1;
        end
    end

    // Offers one sample and returns at the edge where its transfer happens.
    // Within this task valid is only lowered for a gap, never between two back-to-back transfers.
    task automatic send_sample(input logic [SAMPLE_W-1:0] code);
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= code;
        do begin
            @(posedge clk);
        end while (!sample_ready);
        samples_sent++;
    endtask

    // Stops sending and waits until every predicted block result has been
    // transferred, then lets a sample still in flight run through the datapath.
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (blocks_pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the offset register, then the length register; only called after drain().
    // The length goes out as the full 12-bit word so that bits above the
    // register's width are exercised too.
    task automatic set_config(input logic [SAMPLE_W-1:0] offset, input logic [CFG_DATA_W-1:0] len);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OFFSET_CODE;
        cfg_data  <= offset;
        @(posedge clk);
        cfg_index <= CFG_BLOCK_LEN;
        cfg_data  <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int shape,
                                                        input logic [SAMPLE_W-1:0] offset);
        int code;
        case (shape)
            SHAPE_EXTREMES: code = $urandom_range(0, 1) ? 4095 : 0;
            SHAPE_NEAR_DC:  code = int'(offset) + $urandom_range(0, 64) - 32;
            default:        code = $urandom_range(0, 4095);
        endcase
        if (code < 0) begin
            code = 0;
        end else if (code > 4095) begin
            code = 4095;
        end
        return code[SAMPLE_W-1:0];
    endfunction

    initial begin
        int                    phase_items;
        int                    shape;
        int                    pick;
        logic [SAMPLE_W-1:0]   offset;
        logic [CFG_DATA_W-1:0] len_word;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // One full block under the reset defaults: offset 2048, 50 samples per block.
        repeat (50) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        drain();

        // Directed part. Single-sample blocks at both offset extremes with both
        // sample extremes, so zero and full-scale deviation each close a block.
        set_config(12'd0, 12'd1);
        send_sample(12'd0);
        send_sample(12'd4095);
        drain();
        set_config(12'd4095, 12'd1);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);
        drain();

        // A block length of zero behaves as one.
        set_config(12'd2048, 12'd0);
        send_sample(12'd0);
        drain();

        // Bits above the length register are dropped: this word means two.
        set_config(12'd1000, 12'hF82);
        send_sample(12'd3000);
        send_sample(12'd5);
        drain();

        // Length lowered mid-block below the samples already gathered:
        // the very next sample has to close the block.
        set_config(12'd100, 12'd8);
        repeat (5) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        drain();
        set_config(12'd100, 12'd3);
        send_sample(12'd4000);
        drain();

        // Length raised mid-block: the block runs on to the new length.
        set_config(12'd100, 12'd4);
        repeat (2) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        drain();
        set_config(12'd100, 12'd6);
        repeat (4) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        drain();

        // Largest sum the accumulator can see: a length above the maximum
        // saturates to 64 and every sample is a full-scale deviation.
        set_config(12'd0, 12'hFFF);
        repeat (64) send_sample(12'd4095);
        drain();

        // Random phases. Each picks an offset, a block length and a sample shape;
        // phase lengths rarely match the block length, so many register writes
        // land in the middle of a block. Short blocks dominate to keep results coming.
        while (samples_sent < SAMPLE_TARGET) begin
            if (samples_sent >= SAMPLE_TARGET - GAPLESS_TAIL) begin
                send_gaps   = 1'b0;
                ready_gaps  = 1'b0;
                phase_items = GAPLESS_TAIL;
            end else begin
                send_gaps   = $urandom_range(0, 3) != 0;
                ready_gaps  = $urandom_range(0, 3) != 0;
                phase_items = $urandom_range(10, 50);
            end

            pick = $urandom_range(0, 5);
            case (pick)
                0:       offset = 12'd0;
                1:       offset = 12'd4095;
                2:       offset = 12'd2048;
                default: offset = SAMPLE_W'($urandom_range(0, 4095));
            endcase

            pick = $urandom_range(0, 9);
            case (pick)
                0:       len_word = 12'd0;
                1:       len_word = CFG_DATA_W'($urandom_range(64, 127));
                2:       len_word = CFG_DATA_W'($urandom_range(17, 64));
                default: len_word = CFG_DATA_W'($urandom_range(1, 16));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                len_word[CFG_DATA_W-1:LEN_W] = 5'($urandom);
            end

            shape = $urandom_range(SHAPE_UNIFORM, SHAPE_NEAR_DC);
            set_config(offset, len_word);
            repeat (phase_items) begin
                send_sample(pick_sample(shape, offset));
                // Now and then the sender holds off until the meter has emptied.
                if (send_gaps && $urandom_range(0, 39) == 0) begin
                    drain();
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
